// ===== hdl/lr_pkg.sv =====
package lr_pkg;

	localparam int COORD_W = 16;
	localparam int PIX_W = 6;
	localparam int ADDR_W = 18;
	localparam int STRIDE_W = 13;
	localparam int COLOR_W = 32;
	localparam int ERR_W = 10;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd64;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hff0f0fff;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} line_item_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [ADDR_W-1:0]  pixel_address;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_pixel;
	} pixel_item_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_START,
		EMIT_INTERIOR,
		EMIT_FINISH
	} emit_t;

	// controller to datapath
	typedef struct packed {
		logic  load;
		logic  setup;
		emit_t emit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic on_map;
		logic has_interior;
		logic last_interior;
		logic slot_free;
	} sts_t;

endpackage

// ===== hdl/lr_stream_if.sv =====
interface lr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/lr_ctrl.sv =====
module lr_ctrl
	import lr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_START,
		ST_INTERIOR,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign cmd_ready = (state_q == ST_IDLE);

	always_comb begin
		ctl = '0;
		ctl.emit = EMIT_NONE;
		unique case (state_q)
			ST_IDLE:     ctl.load = cmd_valid;
			ST_SETUP:    ctl.setup = 1'b1;
			ST_START:    if (sts.slot_free) ctl.emit = EMIT_START;
			ST_INTERIOR: if (sts.slot_free) ctl.emit = EMIT_INTERIOR;
			ST_FINISH:   if (sts.slot_free) ctl.emit = EMIT_FINISH;
			default:     ctl.emit = EMIT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					// off-map lines produce nothing
					state_q <= sts.on_map ? ST_START : ST_IDLE;
				end
				ST_START: begin
					if (sts.slot_free) state_q <= sts.has_interior ? ST_INTERIOR : ST_FINISH;
				end
				ST_INTERIOR: begin
					if (sts.slot_free && sts.last_interior) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (sts.slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/lr_datapath.sv =====
module lr_datapath
	import lr_pkg::*;
#(
	parameter int MAP_WIDTH = 64,
	parameter int MAP_HEIGHT = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  line_item_t             line_in,
	input  ctl_t                   ctl,
	output sts_t                   sts,
	output logic                   pix_valid,
	input  logic                   pix_ready,
	output pixel_item_t            pix_out
);

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DRAW_COLOR = 2'd1;

	logic [STRIDE_W-1:0] row_stride_q;
	logic [COLOR_W-1:0]  draw_color_q;

	logic [PIX_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic             on_map_q;
	logic             steep_q, rising_q, has_int_q;
	logic [PIX_W-1:0] major_q, minor_q, count_q;
	logic [PIX_W-1:0] cur_x_q, cur_y_q;
	logic signed [ERR_W-1:0] err_q;

	logic        pix_valid_q;
	pixel_item_t pix_q;

	function automatic logic on_map_pt(logic signed [COORD_W-1:0] x,
					   logic signed [COORD_W-1:0] y);
		return !x[COORD_W-1] && (x < COORD_W'(MAP_WIDTH))
			&& !y[COORD_W-1] && (y < COORD_W'(MAP_HEIGHT));
	endfunction

	// load: order endpoints by x and check the map bounds
	logic swap;
	assign swap = (line_in.end_x < line_in.start_x);

	// setup: deltas, octant and initial decision value
	logic [PIX_W-1:0]   dx, ady, major, minor;
	logic signed [PIX_W:0] dy;
	logic               steep;
	always_comb begin
		dx = x1_q - x0_q;
		dy = $signed({1'b0, y1_q}) - $signed({1'b0, y0_q});
		ady = dy[PIX_W] ? PIX_W'(-dy) : dy[PIX_W-1:0];
		steep = (dx <= ady);
		major = steep ? ady : dx;
		minor = steep ? dx : ady;
	end

	// step logic
	logic             err_pos;
	logic [PIX_W-1:0] ystep;
	logic signed [ERR_W-1:0] err_nx;
	assign err_pos = !err_q[ERR_W-1] && (err_q != '0);
	assign ystep = rising_q ? PIX_W'(1) : '1;
	assign err_nx = err_q + $signed({(ERR_W-PIX_W-1)'(0), minor_q, 1'b0})
		- (err_pos ? $signed({(ERR_W-PIX_W-1)'(0), major_q, 1'b0}) : '0);

	// pixel to emit
	logic [PIX_W-1:0] px, py;
	logic             plast;
	logic [STRIDE_W+PIX_W-1:0] row_off;
	always_comb begin
		px = cur_x_q;
		py = cur_y_q;
		plast = 1'b0;
		unique case (ctl.emit)
			EMIT_START: begin
				px = x0_q;
				py = y0_q;
			end
			EMIT_FINISH: begin
				px = x1_q;
				py = y1_q;
				plast = 1'b1;
			end
			default: begin
				px = cur_x_q;
				py = cur_y_q;
			end
		endcase
		row_off = (STRIDE_W+PIX_W)'(row_stride_q) * (STRIDE_W+PIX_W)'(py);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q <= STRIDE_RESET;
			draw_color_q <= COLOR_RESET;
			pix_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ROW_STRIDE) row_stride_q <= cfg_data[STRIDE_W-1:0];
				else if (cfg_index == REG_DRAW_COLOR) draw_color_q <= cfg_data[COLOR_W-1:0];
			end
			if (ctl.emit != EMIT_NONE) pix_valid_q <= 1'b1;
			else if (pix_ready) pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x0_q <= swap ? line_in.end_x[PIX_W-1:0] : line_in.start_x[PIX_W-1:0];
			y0_q <= swap ? line_in.end_y[PIX_W-1:0] : line_in.start_y[PIX_W-1:0];
			x1_q <= swap ? line_in.start_x[PIX_W-1:0] : line_in.end_x[PIX_W-1:0];
			y1_q <= swap ? line_in.start_y[PIX_W-1:0] : line_in.end_y[PIX_W-1:0];
			on_map_q <= on_map_pt(line_in.start_x, line_in.start_y)
				&& on_map_pt(line_in.end_x, line_in.end_y);
		end
		if (ctl.setup) begin
			steep_q <= steep;
			rising_q <= !dy[PIX_W] && (dy != '0);
			major_q <= major;
			minor_q <= minor;
			has_int_q <= (major > PIX_W'(1));
			count_q <= major - PIX_W'(1);
			err_q <= $signed({(ERR_W-PIX_W-1)'(0), minor, 1'b0})
				- $signed({(ERR_W-PIX_W)'(0), major});
		end
		unique case (ctl.emit)
			EMIT_START: begin
				// first interior point is one major step from the start
				cur_x_q <= steep_q ? x0_q : x0_q + PIX_W'(1);
				cur_y_q <= steep_q ? y0_q + ystep : y0_q;
			end
			EMIT_INTERIOR: begin
				if (steep_q) begin
					cur_y_q <= cur_y_q + ystep;
					if (err_pos) cur_x_q <= cur_x_q + PIX_W'(1);
				end else begin
					cur_x_q <= cur_x_q + PIX_W'(1);
					if (err_pos) cur_y_q <= cur_y_q + ystep;
				end
				err_q <= err_nx;
				count_q <= count_q - PIX_W'(1);
			end
			default: ;
		endcase
		if (ctl.emit != EMIT_NONE) begin
			pix_q.pixel_x <= px;
			pix_q.pixel_y <= py;
			pix_q.pixel_address <= ADDR_W'(row_off) + ADDR_W'(px);
			pix_q.pixel_color <= draw_color_q;
			pix_q.last_pixel <= plast;
		end
	end

	assign sts.on_map = on_map_q;
	assign sts.has_interior = has_int_q;
	assign sts.last_interior = (count_q == PIX_W'(1));
	assign sts.slot_free = !pix_valid_q || pix_ready;

	assign pix_valid = pix_valid_q;
	assign pix_out = pix_q;

endmodule

// ===== hdl/line_rasterizer.sv =====
// line rasterizer: bresenham line drawing onto a small pixel map
//
// cmd carries one line item (two signed endpoints). pix carries one pixel
// write per item: column, row, word address x + row_stride*y (wrapping at
// 18 bits), color and a last flag on the final write of the line.
// cfg_we/cfg_index/cfg_data write row_stride (index 0) or draw_color
// (index 1); other indexes are ignored. write them only while idle.
//
// a line is accepted only when the previous one has emitted its last pixel.
// an accepted line is loaded, passes a setup state and then emits its
// start point, its interior points and its end point. a line with an
// endpoint off the map is loaded and set up but emits nothing. the pace
// is set by the single stepping unit, one pixel per cycle while the output
// register is empty or being taken. a zero-length line writes its point
// twice.
//
// the pixel output register holds a pixel until pix.ready; the stepper
// waits while it is full and not taken, so a stalled receiver pauses the
// line. reset (arst_n low) returns to idle, drops any pending pixel and
// restores row_stride to 64 and draw_color to 0xff0f0fff.
module line_rasterizer
	import lr_pkg::*;
#(
	parameter int MAP_WIDTH = 64,
	parameter int MAP_HEIGHT = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	lr_stream_if.sink              cmd,
	lr_stream_if.source            pix
);

	ctl_t ctl;
	sts_t sts;
	line_item_t  line_in;
	pixel_item_t pix_out;

	assign line_in = cmd.payload;
	assign pix.payload = pix_out;

	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	lr_datapath #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.line_in   (line_in),
		.ctl       (ctl),
		.sts       (sts),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.pix_out   (pix_out)
	);

	// no new pixel appears in the cycle right after a line is taken
	a_setup_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !$rose(pix.valid))
		else $error("pixel emitted during line setup");

	// every emitted pixel lies on the map
	a_on_map: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> ({1'b0, pix.payload.pixel_x} < (PIX_W+1)'(MAP_WIDTH))
			&& ({1'b0, pix.payload.pixel_y} < (PIX_W+1)'(MAP_HEIGHT)))
		else $error("pixel outside the map");

	// pixels of one line come without bubbles
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && !pix.payload.last_pixel) |=> pix.valid)
		else $error("gap inside a line");

endmodule
